// File: hdl/y2argb_pkg.sv
// shared types and constants for the ycbcr to argb1555 pixel unit
package y2argb_pkg;

    // field widths
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned GAIN_W   = 18;
    localparam int unsigned TERM_W   = 10;   // held chroma term, covers -448..448
    localparam int unsigned WORD_W   = 16;

    // sample limits
    localparam logic [SAMPLE_W-1:0] LUMA_MIN   = 8'd16;
    localparam logic [SAMPLE_W-1:0] LUMA_MAX   = 8'd235;
    localparam logic [SAMPLE_W-1:0] CHROMA_MIN = 8'd16;
    localparam logic [SAMPLE_W-1:0] CHROMA_MAX = 8'd240;
    localparam logic [SAMPLE_W-1:0] CHROMA_MID = 8'd128;
    localparam logic [SAMPLE_W-1:0] CHAN_MAX   = 8'hFF;
    localparam logic [WORD_W-1:0]   ALPHA_BIT  = 16'h8000;

    // gain reset values, Q16
    localparam logic [GAIN_W-1:0] CR_RED_RST   = 18'd104597;
    localparam logic [GAIN_W-1:0] CR_GREEN_RST = 18'd53279;
    localparam logic [GAIN_W-1:0] CB_GREEN_RST = 18'd25624;
    localparam logic [GAIN_W-1:0] CB_BLUE_RST  = 18'd132251;

    // register indexes on the config port
    typedef enum logic [1:0] {
        REG_CR_RED   = 2'd0,
        REG_CR_GREEN = 2'd1,
        REG_CB_GREEN = 2'd2,
        REG_CB_BLUE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] cr_red;
        logic [GAIN_W-1:0] cr_green;
        logic [GAIN_W-1:0] cb_green;
        logic [GAIN_W-1:0] cb_blue;
    } t_gains;

    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green_cr;
        logic signed [TERM_W-1:0] green_cb;
        logic signed [TERM_W-1:0] blue;
    } t_terms;

endpackage

// File: hdl/y2argb_chroma_terms.sv
// chroma centering, q16 gain products and the held chroma terms
module y2argb_chroma_terms (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [y2argb_pkg::SAMPLE_W-1:0]   i_cb,
    input  logic [y2argb_pkg::SAMPLE_W-1:0]   i_cr,
    input  y2argb_pkg::t_gains                i_gains,
    output y2argb_pkg::t_terms                o_terms
);
    import y2argb_pkg::*;

    localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 1;

    logic [SAMPLE_W-1:0]      cb_clamped;
    logic [SAMPLE_W-1:0]      cr_clamped;
    logic signed [SAMPLE_W:0] cb_center;
    logic signed [SAMPLE_W:0] cr_center;
    logic signed [PROD_W-1:0] prod_red;
    logic signed [PROD_W-1:0] prod_green_cr;
    logic signed [PROD_W-1:0] prod_green_cb;
    logic signed [PROD_W-1:0] prod_blue;
    t_terms                   n_terms;
    t_terms                   r_terms;

    // clamp to the chroma range and center on zero
    always_comb begin
        if (i_cb < CHROMA_MIN) begin
            cb_clamped = CHROMA_MIN;
        end else if (i_cb > CHROMA_MAX) begin
            cb_clamped = CHROMA_MAX;
        end else begin
            cb_clamped = i_cb;
        end
        if (i_cr < CHROMA_MIN) begin
            cr_clamped = CHROMA_MIN;
        end else if (i_cr > CHROMA_MAX) begin
            cr_clamped = CHROMA_MAX;
        end else begin
            cr_clamped = i_cr;
        end
        cb_center = $signed({1'b0, cb_clamped}) - $signed({1'b0, CHROMA_MID});
        cr_center = $signed({1'b0, cr_clamped}) - $signed({1'b0, CHROMA_MID});
    end

    // signed products; dropping 16 fraction bits of a two's complement value is a floor
    always_comb begin
        prod_red      = PROD_W'(cr_center) * $signed({{(PROD_W-GAIN_W){1'b0}}, i_gains.cr_red});
        prod_green_cr = PROD_W'(cr_center) * $signed({{(PROD_W-GAIN_W){1'b0}}, i_gains.cr_green});
        prod_green_cb = PROD_W'(cb_center) * $signed({{(PROD_W-GAIN_W){1'b0}}, i_gains.cb_green});
        prod_blue     = PROD_W'(cb_center) * $signed({{(PROD_W-GAIN_W){1'b0}}, i_gains.cb_blue});
        n_terms.red      = prod_red[16 +: TERM_W];
        n_terms.green_cr = prod_green_cr[16 +: TERM_W];
        n_terms.green_cb = prod_green_cb[16 +: TERM_W];
        n_terms.blue     = prod_blue[16 +: TERM_W];
    end

    // held terms, replaced only by a pixel that brings chroma
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terms <= '0;
        end else if (i_load) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// File: hdl/ycbcr_to_argb1555_pixel_unit.sv
// top level of the ycbcr to argb1555 pixel unit
//
//  channel   direction  data                                   sideband
//  s_axis    in         tdata: luma, chroma_blue, chroma_red    tuser: new_chroma
//  m_axis    out        tdata: pixel_word                       -
//  apb       in         four 18-bit q16 gains at 0x0..0xC       pready tied high
//
// one item per clock sustained while m_axis_tready holds; an accepted item passes through
// the input register, the product/held-term register and the output register, in that order
// the gain multipliers feed the held-term register, the add and saturate feed the output
// synchronous active-low reset clears valids and held terms (grey output), gains go to defaults
// a stalled output keeps accepting until all three stages are full
module ycbcr_to_argb1555_pixel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
    input  logic        s_axis_tuser,   // [0] new_chroma
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pixel_word
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import y2argb_pkg::*;

    localparam int unsigned SUM_W = 12;

    t_gains                r_gains;
    t_reg_idx              reg_idx;
    logic [GAIN_W-1:0]     rd_gain;

    logic                  r_s1_valid;
    logic [SAMPLE_W-1:0]   r_s1_luma;
    logic [SAMPLE_W-1:0]   r_s1_cb;
    logic [SAMPLE_W-1:0]   r_s1_cr;
    logic                  r_s1_load;
    logic                  r_s2_valid;
    logic [SAMPLE_W-1:0]   r_s2_luma;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_word;

    logic                  s1_ready;
    logic                  s2_ready;
    logic                  out_ready;
    logic                  s1_move;
    logic [SAMPLE_W-1:0]   n_s2_luma;
    t_terms                terms;
    logic signed [SUM_W-1:0] sum_red;
    logic signed [SUM_W-1:0] sum_green;
    logic signed [SUM_W-1:0] sum_blue;
    logic [4:0]            red5;
    logic [4:0]            green5;
    logic [4:0]            blue5;
    logic [WORD_W-1:0]     n_out_word;

    // config registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.cr_red   <= CR_RED_RST;
            r_gains.cr_green <= CR_GREEN_RST;
            r_gains.cb_green <= CB_GREEN_RST;
            r_gains.cb_blue  <= CB_BLUE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_CR_RED:   r_gains.cr_red   <= pwdata[GAIN_W-1:0];
                REG_CR_GREEN: r_gains.cr_green <= pwdata[GAIN_W-1:0];
                REG_CB_GREEN: r_gains.cb_green <= pwdata[GAIN_W-1:0];
                REG_CB_BLUE:  r_gains.cb_blue  <= pwdata[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (reg_idx)
            REG_CR_RED:   rd_gain = r_gains.cr_red;
            REG_CR_GREEN: rd_gain = r_gains.cr_green;
            REG_CB_GREEN: rd_gain = r_gains.cb_green;
            REG_CB_BLUE:  rd_gain = r_gains.cb_blue;
            default:      rd_gain = '0;
        endcase
    end
    assign prdata = {{(32-GAIN_W){1'b0}}, rd_gain};

    // stage handshake: a stage advances when the next one is empty or advancing
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s2_ready      = !r_s2_valid || out_ready;
    assign s1_ready      = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready;
    assign s1_move       = r_s1_valid && s2_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && s_axis_tvalid) begin
            r_s1_luma <= s_axis_tdata[7:0];
            r_s1_cb   <= s_axis_tdata[15:8];
            r_s1_cr   <= s_axis_tdata[23:16];
            r_s1_load <= s_axis_tuser;
        end
    end

    // luma clamp and offset
    always_comb begin
        if (r_s1_luma < LUMA_MIN) begin
            n_s2_luma = '0;
        end else if (r_s1_luma > LUMA_MAX) begin
            n_s2_luma = LUMA_MAX - LUMA_MIN;
        end else begin
            n_s2_luma = r_s1_luma - LUMA_MIN;
        end
    end

    // held chroma terms follow the item into the second stage
    y2argb_chroma_terms u_chroma_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_move && r_s1_load),
        .i_cb    (r_s1_cb),
        .i_cr    (r_s1_cr),
        .i_gains (r_gains),
        .o_terms (terms)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_luma <= n_s2_luma;
        end
    end

    // channel sums, saturate to 0..255, keep the top five bits
    always_comb begin
        sum_red   = $signed({{(SUM_W-SAMPLE_W){1'b0}}, r_s2_luma}) + SUM_W'(terms.red);
        sum_green = $signed({{(SUM_W-SAMPLE_W){1'b0}}, r_s2_luma}) - SUM_W'(terms.green_cr)
                    - SUM_W'(terms.green_cb);
        sum_blue  = $signed({{(SUM_W-SAMPLE_W){1'b0}}, r_s2_luma}) + SUM_W'(terms.blue);

        if (sum_red < 0) begin
            red5 = '0;
        end else if (sum_red > $signed({{(SUM_W-SAMPLE_W){1'b0}}, CHAN_MAX})) begin
            red5 = CHAN_MAX[7:3];
        end else begin
            red5 = sum_red[7:3];
        end
        if (sum_green < 0) begin
            green5 = '0;
        end else if (sum_green > $signed({{(SUM_W-SAMPLE_W){1'b0}}, CHAN_MAX})) begin
            green5 = CHAN_MAX[7:3];
        end else begin
            green5 = sum_green[7:3];
        end
        if (sum_blue < 0) begin
            blue5 = '0;
        end else if (sum_blue > $signed({{(SUM_W-SAMPLE_W){1'b0}}, CHAN_MAX})) begin
            blue5 = CHAN_MAX[7:3];
        end else begin
            blue5 = sum_blue[7:3];
        end

        n_out_word = ALPHA_BIT | {1'b0, red5, green5, blue5};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s2_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

endmodule

// File: sim/testbench.sv
// self-checking bench for the ycbcr to argb1555 pixel unit: predicts each word, checks streams
`timescale 1ns / 100ps

module testbench;
    import y2argb_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_PIXELS = 270;
    localparam logic [31:0] GAIN_ALL_ONES = 32'h0003_FFFF;

    // predicts display words from accepted pixels and checks them in order
    class argb1555_checker;
        logic [GAIN_W-1:0]  gain [4];
        logic signed [17:0] red_term;
        logic signed [17:0] green_cr_term;
        logic signed [17:0] green_cb_term;
        logic signed [17:0] blue_term;
        logic [WORD_W-1:0]  expected_words [$];
        int unsigned        mismatches;

        function void reset_state();
            gain[REG_CR_RED]   = CR_RED_RST;
            gain[REG_CR_GREEN] = CR_GREEN_RST;
            gain[REG_CB_GREEN] = CB_GREEN_RST;
            gain[REG_CB_BLUE]  = CB_BLUE_RST;
            red_term      = '0;
            green_cr_term = '0;
            green_cb_term = '0;
            blue_term     = '0;
            expected_words.delete();
            mismatches = 0;
        endfunction

        function void set_gain(t_reg_idx idx, logic [31:0] value);
            gain[idx] = value[GAIN_W-1:0];
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // floor of centered sample times q16 gain
        function logic signed [17:0] scaled(int c, logic [GAIN_W-1:0] g);
            longint prod;
            prod = longint'(c) * longint'({1'b0, g});
            return 18'(prod >>> 16);
        endfunction

        function int clip(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // saturate to a byte, keep the top five bits
        function logic [4:0] chan5(int v);
            int s;
            s = clip(v, 0, int'(CHAN_MAX));
            return s[7:3];
        endfunction

        function void note_pixel(logic [7:0] y_in, logic [7:0] cb_in, logic [7:0] cr_in,
                                 logic load);
            int y, cb, cr, r, g, b;
            y = clip(int'(y_in), int'(LUMA_MIN), int'(LUMA_MAX)) - int'(LUMA_MIN);
            if (load) begin
                cb = clip(int'(cb_in), int'(CHROMA_MIN), int'(CHROMA_MAX)) - int'(CHROMA_MID);
                cr = clip(int'(cr_in), int'(CHROMA_MIN), int'(CHROMA_MAX)) - int'(CHROMA_MID);
                red_term      = scaled(cr, gain[REG_CR_RED]);
                green_cr_term = scaled(cr, gain[REG_CR_GREEN]);
                green_cb_term = scaled(cb, gain[REG_CB_GREEN]);
                blue_term     = scaled(cb, gain[REG_CB_BLUE]);
            end
            r = y + int'(red_term);
            g = y - int'(green_cr_term) - int'(green_cb_term);
            b = y + int'(blue_term);
            expected_words.push_back(ALPHA_BIT | {1'b0, chan5(r), chan5(g), chan5(b)});
        endfunction

        function void check_word(logic [WORD_W-1:0] actual);
            logic [WORD_W-1:0] want;
            if (expected_words.size() == 0) begin
                $display("%0t: pixel word %h arrived with none expected", $time, actual);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (actual !== want) begin
                    $display("%0t: pixel word mismatch, expected %h actual %h",
                             $time, want, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
    logic        s_axis_tuser  = 1'b0; // [0] new_chroma
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [15:0] pixel_word
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    argb1555_checker words = new();
    bit steady   = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;   // receiver holds off for a long stretch

    ycbcr_to_argb1555_pixel_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // predict on every accepted input item
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            words.note_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                             s_axis_tuser);
    end

    // check every accepted output item
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            words.check_word(m_axis_tdata);
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // one pixel item, then a random gap
    task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                              input logic nc);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cr, cb, y};
        s_axis_tuser  <= nc;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until every expected word has come; the first edge lets the last accept be noted
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // apb setup and access phases, then back to idle
    task automatic apb_xfer(input logic wr, input t_reg_idx idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write a gain and read it back
    task automatic write_gain(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        words.set_gain(idx, value);
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== {14'b0, value[GAIN_W-1:0]}) begin
            $display("%0t: gain %0d readback mismatch, expected %h actual %h",
                     $time, idx, {14'b0, value[GAIN_W-1:0]}, rd);
            words.mismatches++;
        end
    endtask

    task automatic write_gains(input logic [31:0] cr_red, input logic [31:0] cr_green,
                               input logic [31:0] cb_green, input logic [31:0] cb_blue);
        write_gain(REG_CR_RED, cr_red);
        write_gain(REG_CR_GREEN, cr_green);
        write_gain(REG_CB_GREEN, cb_green);
        write_gain(REG_CB_BLUE, cb_blue);
    endtask

    // sample biased toward the clamp edges
    function automatic logic [7:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 8'd0;
        if (r < 8) return 8'd255;
        if (r < 11) return 8'd16;
        if (r < 14) return 8'd235;
        if (r < 17) return 8'd240;
        return 8'($urandom_range(0, 255));
    endfunction

    // random pixels, chroma mostly on even columns
    task automatic send_random(input int count);
        logic nc;
        for (int i = 0; i < count; i++) begin
            nc = (i % 2 == 0);
            if ($urandom_range(0, 4) == 0) nc = ~nc;
            send_pixel(pick_sample(), pick_sample(), pick_sample(), nc);
        end
    endtask

    // main sequence
    initial begin
        words.reset_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grey output before any chroma, luma clamp edges
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd15,  8'd255, 8'd0,   1'b0);
        send_pixel(8'd16,  8'd255, 8'd0,   1'b0);
        send_pixel(8'd17,  8'd0,   8'd255, 1'b0);
        send_pixel(8'd128, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd235, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd236, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        // chroma loads at and past the clamp edges
        send_pixel(8'd128, 8'd0,   8'd0,   1'b1);
        send_pixel(8'd128, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd128, 8'd16,  8'd16,  1'b1);
        send_pixel(8'd128, 8'd240, 8'd240, 1'b1);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        send_pixel(8'd128, 8'd15,  8'd241, 1'b1);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b1);
        send_pixel(8'd235, 8'd127, 8'd129, 1'b1);
        // held terms reused apart from one reload, luma still clamped on every pixel
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd100, 8'hAA,  8'h55,  1'b0);
        send_pixel(8'd16,  8'd240, 8'd16,  1'b1);
        send_pixel(8'd235, 8'd0,   8'd0,   1'b0);
        drain();

        // gain settings, extremes among them
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_gains(GAIN_ALL_ONES, GAIN_ALL_ONES, GAIN_ALL_ONES, GAIN_ALL_ONES);
                1: write_gains('0, '0, '0, '0);
                2: write_gains($urandom(), $urandom(), $urandom(), $urandom());
                3: write_gains($urandom_range(0, 262143), $urandom_range(0, 262143),
                               $urandom_range(0, 262143), $urandom_range(0, 262143));
                4: write_gains(32'(CR_RED_RST), 32'(CR_GREEN_RST), 32'(CB_GREEN_RST),
                               32'(CB_BLUE_RST));
                default: write_gains(GAIN_ALL_ONES, '0, GAIN_ALL_ONES, '0);
            endcase
            // one phase runs flat out against a long receiver hold-off
            if (p == 3) begin
                steady   = 1'b1;
                hold_req = 1'b1;
            end
            send_random(PHASE_PIXELS);
            drain();
            steady = 1'b0;
        end

        drain();
        if (words.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
